[src/svps_pkg.sv]
// shared types and constants for the valve stepper step generator
// used by every module under src, no dependencies of its own
package svps_pkg;

    localparam int POS_W   = 14;
    localparam int CNT_W   = 15;
    localparam int OFS_W   = 12;
    localparam int FLT_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 15;

    localparam logic [1:0] DUTY_SKIP = 2'd2;

    typedef enum logic [2:0] {
        FUNC_TICK      = 3'd0,
        FUNC_SET_REQ   = 3'd1,
        FUNC_RESET     = 3'd2,
        FUNC_RESYNC    = 3'd3,
        FUNC_OPEN_ALL  = 3'd4,
        FUNC_DISCHARGE = 3'd5
    } t_func;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MAX_STEPS      = 3'd0,
        CFG_CLOSED_LIMIT   = 3'd1,
        CFG_OFFSET_STEPS   = 3'd2,
        CFG_RESET_OVERDRV  = 3'd3,
        CFG_RESYNC_OVERDRV = 3'd4,
        CFG_DISCHARGE_STEP = 3'd5,
        CFG_OPEN_POSITION  = 3'd6,
        CFG_LOW_SPEED      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_func              func;
        logic [POS_W-1:0]   request_position;
        logic               fault_n;
        logic               unit_stopped;
    } t_req;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic               driver_enable;
        logic               led_on;
        logic               high_current;
        logic               driver_reset;
        logic [CNT_W-1:0]   valve_position;
        logic [CNT_W-1:0]   motor_position;
        logic               init_busy;
        logic [FLT_W-1:0]   fault_count;
    } t_res;

    typedef struct packed {
        logic [POS_W-1:0]   max_steps;
        logic [POS_W-1:0]   closed_limit;
        logic [OFS_W-1:0]   offset_steps;
        logic [CNT_W-1:0]   reset_overdrive_steps;
        logic [CNT_W-1:0]   resync_overdrive_steps;
        logic [OFS_W-1:0]   discharge_step;
        logic [POS_W-1:0]   open_position;
        logic               low_speed_mode;
    } t_cfg;

endpackage

[src/svps_cfg.sv]
// configuration register file of the valve stepper
// depends on svps_pkg
module svps_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [svps_pkg::CIDX_W-1:0]  i_index,
    input  logic [svps_pkg::CDAT_W-1:0]  i_data,
    output svps_pkg::t_cfg               o_cfg
);
    import svps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_steps              <= 14'd7680;
            r_cfg.closed_limit           <= 14'd0;
            r_cfg.offset_steps           <= 12'd0;
            r_cfg.reset_overdrive_steps  <= 15'd8000;
            r_cfg.resync_overdrive_steps <= 15'd1000;
            r_cfg.discharge_step         <= 12'd16;
            r_cfg.open_position          <= 14'd7680;
            r_cfg.low_speed_mode         <= 1'b0;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_MAX_STEPS:      r_cfg.max_steps              <= i_data[POS_W-1:0];
                CFG_CLOSED_LIMIT:   r_cfg.closed_limit           <= i_data[POS_W-1:0];
                CFG_OFFSET_STEPS:   r_cfg.offset_steps           <= i_data[OFS_W-1:0];
                CFG_RESET_OVERDRV:  r_cfg.reset_overdrive_steps  <= i_data[CNT_W-1:0];
                CFG_RESYNC_OVERDRV: r_cfg.resync_overdrive_steps <= i_data[CNT_W-1:0];
                CFG_DISCHARGE_STEP: r_cfg.discharge_step         <= i_data[OFS_W-1:0];
                CFG_OPEN_POSITION:  r_cfg.open_position          <= i_data[POS_W-1:0];
                CFG_LOW_SPEED:      r_cfg.low_speed_mode         <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/svps_core.sv]
// valve stepper state and single pass command/tick logic
// depends on svps_pkg, configuration comes from svps_cfg
module svps_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  svps_pkg::t_req  i_req,
    input  svps_pkg::t_cfg  i_cfg,
    output svps_pkg::t_res  o_res
);
    import svps_pkg::*;

    logic [POS_W-1:0] r_req_pos, n_req_pos;
    logic [CNT_W-1:0] r_target, n_target;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_shown, n_shown;
    logic [1:0]       r_duty, n_duty;
    logic             r_dir, n_dir;
    logic             r_enable, n_enable;
    logic             r_lamp, n_lamp;
    logic             r_current, n_current;
    logic             r_busy, n_busy;
    logic [FLT_W-1:0] r_faults, n_faults;

    logic [POS_W-1:0] clamp_hi, clamp_pos;
    logic [CNT_W-1:0] offset_ext, dstep_ext;
    logic [CNT_W-1:0] tick_target, count_step, shown_step;
    logic             tick_dir, moving, skip, hold;
    logic             n_step, n_drv_rst;

    always_comb begin
        offset_ext  = {{(CNT_W-OFS_W){1'b0}}, i_cfg.offset_steps};
        dstep_ext   = {{(CNT_W-OFS_W){1'b0}}, i_cfg.discharge_step};
        clamp_hi    = (r_req_pos > i_cfg.max_steps) ? i_cfg.max_steps : r_req_pos;
        clamp_pos   = (clamp_hi < i_cfg.closed_limit) ? i_cfg.closed_limit : clamp_hi;
        if (clamp_pos != '0) begin
            tick_target = {{(CNT_W-POS_W){1'b0}}, clamp_pos} + offset_ext;
        end else begin
            tick_target = (r_target > offset_ext) ? offset_ext : r_target;
        end
        tick_dir    = tick_target > r_count;
        moving      = tick_target != r_count;
        skip        = i_cfg.low_speed_mode && (r_duty != 2'd0);
        hold        = skip && (r_duty <= DUTY_SKIP);
        count_step  = tick_dir ? r_count + 1'b1 : r_count - 1'b1;
        shown_step  = (count_step > offset_ext) ? count_step - offset_ext : '0;

        n_req_pos = r_req_pos;
        n_target  = r_target;
        n_count   = r_count;
        n_shown   = r_shown;
        n_duty    = r_duty;
        n_dir     = r_dir;
        n_enable  = r_enable;
        n_lamp    = r_lamp;
        n_current = r_current;
        n_busy    = r_busy;
        n_faults  = r_faults;
        n_step    = 1'b0;
        n_drv_rst = 1'b0;

        if (i_accept) begin
            unique case (i_req.func)
                FUNC_TICK: begin
                    n_req_pos = clamp_pos;
                    n_target  = tick_target;
                    n_dir     = tick_dir;
                    if (skip) begin
                        n_current = 1'b0;
                    end
                    if (hold) begin
                        n_duty = r_duty + 2'd1;
                    end else begin
                        if (skip) begin
                            n_duty = 2'd0;
                        end
                        if (moving) begin
                            n_enable  = 1'b1;
                            n_current = 1'b1;
                            n_lamp    = 1'b1;
                            if (!i_req.fault_n) begin
                                n_faults  = r_faults + 1'b1;
                                n_drv_rst = 1'b1;
                            end
                            n_step  = 1'b1;
                            n_count = count_step;
                            n_shown = shown_step;
                            n_duty  = 2'd1;
                        end else begin
                            n_lamp = 1'b0;
                            if (!i_cfg.low_speed_mode) begin
                                n_current = 1'b0;
                            end
                            n_busy = 1'b0;
                        end
                    end
                end
                FUNC_SET_REQ: begin
                    n_req_pos = i_req.request_position;
                end
                FUNC_RESET: begin
                    n_req_pos = '0;
                    n_count   = i_cfg.reset_overdrive_steps;
                    n_busy    = 1'b1;
                end
                FUNC_RESYNC: begin
                    n_req_pos = '0;
                    n_count   = i_cfg.resync_overdrive_steps;
                    n_busy    = 1'b1;
                end
                FUNC_OPEN_ALL: begin
                    n_req_pos = i_cfg.open_position;
                    n_busy    = 1'b1;
                end
                FUNC_DISCHARGE: begin
                    n_req_pos = '0;
                    if (i_req.unit_stopped || (r_target < dstep_ext)) begin
                        n_target = '0;
                    end else begin
                        n_target = r_target - dstep_ext;
                    end
                    n_busy = 1'b1;
                end
                default: ;
            endcase
        end

        o_res.step_pulse     = n_step;
        o_res.direction      = n_dir;
        o_res.driver_enable  = n_enable;
        o_res.led_on         = n_lamp;
        o_res.high_current   = n_current;
        o_res.driver_reset   = n_drv_rst;
        o_res.valve_position = n_shown;
        o_res.motor_position = n_count;
        o_res.init_busy      = n_busy;
        o_res.fault_count    = n_faults;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_pos <= '0;
            r_target  <= '0;
            r_count   <= '0;
            r_shown   <= '0;
            r_duty    <= '0;
            r_dir     <= 1'b0;
            r_enable  <= 1'b0;
            r_lamp    <= 1'b0;
            r_current <= 1'b0;
            r_busy    <= 1'b0;
            r_faults  <= '0;
        end else begin
            r_req_pos <= n_req_pos;
            r_target  <= n_target;
            r_count   <= n_count;
            r_shown   <= n_shown;
            r_duty    <= n_duty;
            r_dir     <= n_dir;
            r_enable  <= n_enable;
            r_lamp    <= n_lamp;
            r_current <= n_current;
            r_busy    <= n_busy;
            r_faults  <= n_faults;
        end
    end

`ifndef SYNTHESIS
    a_enable_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enable |=> r_enable)
        else $error("driver enable dropped without reset");

    a_faults_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && (i_req.func == FUNC_TICK)) |=> $stable(r_faults))
        else $error("fault count moved without a tick");

    a_one_step_per_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_req.func == FUNC_TICK)) |=>
            (r_count == $past(r_count)) || (r_count == $past(r_count) + 15'd1)
            || (r_count == $past(r_count) - 15'd1))
        else $error("motor count moved by more than one step");
`endif

endmodule

[src/svps_out.sv]
// two entry result buffer, keeps requests flowing while the receiver stalls
// depends on svps_pkg
module svps_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  svps_pkg::t_res  i_res,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_stall,
    output svps_pkg::t_res  o_res
);
    import svps_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_res r_main;
    t_res r_skid;
    logic pop;

    assign pop = r_main_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("request pushed into a full result buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry lost on drain");
`endif

endmodule

[src/stepper_valve_position_stepper.sv]
// Step generator for an expansion-valve stepper motor.
// Request channel: i_req_valid / o_req_stall with payload i_req (func, request
// position, driver fault line, unit stopped). Each request yields exactly one
// result on o_res_valid / i_res_stall with payload o_res (step pulse, direction,
// driver enable, lamp, current level, driver reset, valve and motor positions,
// busy flag, fault count).
// Configuration: i_cfg_valid / o_cfg_ready with register index i_cfg_index and
// data i_cfg_data; ready is always high. Write only while no request is in
// flight.
// Result: each accepted request's result is registered in the result buffer.
// Throughput: one request per cycle while o_req_stall is low; the update of
// positions and flags is one compare/add pass from state to result register.
// Stall: a two entry result buffer absorbs one extra request while the
// receiver stalls; o_req_stall rises only when both entries are full.
// Reset (i_rst_n low, synchronous): all positions, flags and the fault count
// clear, configuration returns to its defaults, the result buffer empties.
// Depends on svps_pkg, svps_cfg, svps_core and svps_out.
module stepper_valve_position_stepper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_stall,
    input  svps_pkg::t_req               i_req,
    output logic                         o_res_valid,
    input  logic                         i_res_stall,
    output svps_pkg::t_res               o_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [svps_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [svps_pkg::CDAT_W-1:0]  i_cfg_data
);
    import svps_pkg::*;

    t_cfg cfg;
    t_res core_res;
    logic accept;
    logic buf_full;

    assign o_cfg_ready = 1'b1;
    assign o_req_stall = buf_full;
    assign accept      = i_req_valid && !buf_full;

    svps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    svps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_cfg    (cfg),
        .o_res    (core_res)
    );

    svps_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (core_res),
        .o_full  (buf_full),
        .o_valid (o_res_valid),
        .i_stall (i_res_stall),
        .o_res   (o_res)
    );

endmodule
